// ===== rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file except utf8d_stream_if imports this package.
package utf8d_pkg;

    localparam int HOLD_DEPTH = 6;
    localparam int CNT_W      = 3;

    localparam logic [15:0] REPL_CHAR = 16'h005F;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic        was_replaced;
        logic        last_of_run;
        logic        text_done;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_byte;    // append accepted byte, start a new run
        logic take_result;  // latch judged result into hold, drop used bytes
        logic push_hold;    // move hold into output register
        logic push_last;    // pushed result closes the run
        logic finish;       // run over; flush buffer if text ended
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stop;         // no further result for this byte
        logic hold_valid;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/utf8d_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload type is set per instance.
interface utf8d_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/utf8d_ctrl.sv =====
// Sequencer of the UTF-8 decoder: accepts a byte, then steps the judge
// once per result. Uses utf8d_pkg command/status structs.
module utf8d_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  utf8d_pkg::ctrl_status_t status,
    output utf8d_pkg::ctrl_cmd_t    cmd
);
    import utf8d_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_JUDGE = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   can_push;

    // a held result can only move on when the output register frees up
    assign can_push = !status.hold_valid || status.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (can_push)
                begin
                    cmd.push_hold = status.hold_valid;
                    if (status.stop)
                    begin
                        cmd.push_last = 1'b1;
                        cmd.finish    = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.take_result = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/utf8d_datapath.sv =====
// Datapath of the UTF-8 decoder: byte buffer, form judge, hold and
// output registers. Uses utf8d_pkg types; driven by utf8d_ctrl.
module utf8d_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8d_pkg::in_item_t     in_item,
    input  utf8d_pkg::ctrl_cmd_t    cmd,
    output utf8d_pkg::ctrl_status_t status,
    input  logic                    out_ready,
    output logic                    out_valid,
    output utf8d_pkg::out_item_t    out_item
);
    import utf8d_pkg::*;

    logic [7:0]  buf_reg [HOLD_DEPTH];
    logic [7:0]  buf_next [HOLD_DEPTH];
    cnt_t        count_reg, count_next;
    cnt_t        nres_reg;
    logic        fin_reg;

    logic        hold_valid_reg;
    logic [15:0] hold_cp_reg;
    logic        hold_rep_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [7:0]  b0, b1, b2;
    cnt_t        j_used, used_eff;
    logic [15:0] j_cp;
    logic        j_rep;
    cnt_t        long_len;
    logic        long_done;
    logic [3:0]  src;

    assign b0 = buf_reg[0];
    assign b1 = buf_reg[1];
    assign b2 = buf_reg[2];

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Entries at or past count hold zero, which doubles as the
    // zero byte assumed after the end of a text.
    function automatic logic known(input cnt_t k, input cnt_t cnt, input logic fin);
        return (k < cnt) || fin;
    endfunction

    always_comb
    begin
        j_used    = '0;
        j_cp      = REPL_CHAR;
        j_rep     = 1'b1;
        long_len  = 3'd4;
        long_done = 1'b0;
        if (!b0[7])
        begin
            j_rep  = 1'b0;
            j_cp   = {8'h00, b0};
            j_used = 3'd1;
        end
        else if (b0 < 8'hC0 || b0 >= 8'hFE)
        begin
            j_used = 3'd1;
        end
        else if (b0 < 8'hE0)
        begin
            if (!known(3'd1, count_reg, fin_reg))
                j_used = 3'd0;
            else if (!is_cont(b1))
                j_used = 3'd1;
            else if (b0[7:1] == 7'h60)
                j_used = 3'd2;  // overlong C0/C1
            else
            begin
                j_rep  = 1'b0;
                j_cp   = {5'b0, b0[4:0], b1[5:0]};
                j_used = 3'd2;
            end
        end
        else if (b0 < 8'hF0)
        begin
            if (!known(3'd1, count_reg, fin_reg))
                j_used = 3'd0;
            else if (!is_cont(b1))
                j_used = 3'd1;
            else if (!known(3'd2, count_reg, fin_reg))
                j_used = 3'd0;
            else if (!is_cont(b2))
                j_used = 3'd2;
            else if (b0[3:0] == 4'hD && b1[5])
                j_used = 3'd3;  // surrogate
            else if (b0 == 8'hE0 && b1[7:5] == 3'b100)
                j_used = 3'd3;  // overlong
            else
            begin
                j_rep  = 1'b0;
                j_cp   = {b0[3:0], b1[5:0], b2[5:0]};
                j_used = 3'd3;
            end
        end
        else
        begin
            // long form: swallow continuation-like bytes up to the length
            long_len = (b0 < 8'hF8) ? 3'd4 : (b0 < 8'hFC) ? 3'd5 : 3'd6;
            for (int k = 1; k < HOLD_DEPTH; k++)
            begin
                if (!long_done && cnt_t'(k) < long_len)
                begin
                    if (!known(cnt_t'(k), count_reg, fin_reg))
                    begin
                        j_used    = 3'd0;
                        long_done = 1'b1;
                    end
                    else if (!buf_reg[k][7])
                    begin
                        j_used    = cnt_t'(k);
                        long_done = 1'b1;
                    end
                end
            end
            if (!long_done)
                j_used = long_len;
        end
    end

    assign used_eff = (j_used > count_reg) ? count_reg : j_used;

    assign status.stop = (count_reg == '0) || (j_used == '0)
                       || (nres_reg == cnt_t'(HOLD_DEPTH));
    assign status.hold_valid = hold_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // buffer next value: append, drop consumed bytes, or flush
    always_comb
    begin
        src        = '0;
        count_next = count_reg;
        for (int i = 0; i < HOLD_DEPTH; i++)
            buf_next[i] = buf_reg[i];
        if (cmd.load_byte)
        begin
            if (count_reg < cnt_t'(HOLD_DEPTH))
            begin
                buf_next[count_reg] = in_item.data_byte;
                count_next          = count_reg + 3'd1;
            end
        end
        else if (cmd.take_result)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                src = 4'(i) + {1'b0, used_eff};
                if (src < 4'(HOLD_DEPTH))
                    buf_next[i] = buf_reg[src[2:0]];
                else
                    buf_next[i] = 8'h00;
            end
            count_next = count_reg - used_eff;
        end
        else if (cmd.finish && fin_reg)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
                buf_next[i] = 8'h00;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
                buf_reg[i] <= 8'h00;
            count_reg      <= '0;
            nres_reg       <= '0;
            fin_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
                buf_reg[i] <= buf_next[i];
            count_reg <= count_next;

            if (cmd.load_byte)
            begin
                fin_reg  <= in_item.end_of_text;
                nres_reg <= '0;
            end
            else if (cmd.take_result)
            begin
                nres_reg <= nres_reg + 3'd1;
            end

            if (cmd.take_result)
                hold_valid_reg <= 1'b1;
            else if (cmd.push_hold)
                hold_valid_reg <= 1'b0;

            if (cmd.push_hold)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_result)
        begin
            hold_cp_reg  <= j_cp;
            hold_rep_reg <= j_rep;
        end
        if (cmd.push_hold)
        begin
            out_reg.code_point   <= hold_cp_reg;
            out_reg.was_replaced <= hold_rep_reg;
            out_reg.last_of_run  <= cmd.push_last;
            out_reg.text_done    <= cmd.push_last && fin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Channel    Dir   Payload                                           Transfer
// bytes      in    data_byte[7:0], end_of_text                       valid & ready
// chars      out   code_point[15:0], was_replaced, last_of_run,      valid & ready
//                  text_done
//
// A byte is accepted, then the judge steps once per result it causes and
// once more to end the run; the judge runs once per cycle on the
// six-entry byte buffer. Each result passes a hold register, so the last
// one is known to close the run before it leaves. Reset clears buffer and
// control. A stalled output holds the judge; no byte is taken mid-run.
//
// Top level of the UTF-8 decoder; depends on utf8d_pkg, utf8d_stream_if,
// utf8d_ctrl and utf8d_datapath.
module utf8_stream_decoder (
    input  logic           clk,
    input  logic           rst_n,
    utf8d_stream_if.sink   bytes,
    utf8d_stream_if.source chars
);
    import utf8d_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    in_item_t     in_item;
    out_item_t    out_item;
    logic         out_valid;
    logic         in_ready;

    assign in_item       = bytes.payload;
    assign bytes.ready   = in_ready;
    assign chars.valid   = out_valid;
    assign chars.payload = out_item;

    utf8d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    utf8d_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_ready (chars.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_decoder: directed byte rows, then random UTF-8 texts.
// Uses utf8d_pkg types and the utf8d_stream_if channel; a local decoder model predicts chars.
module testbench;
    import utf8d_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_BYTES = 205;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 20;
    localparam out_item_t NO_WANT = '0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
        logic       pinned;     // want holds the single char this byte must give
        out_item_t  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    utf8d_stream_if #(.item_t(in_item_t))  bytes_if ();
    utf8d_stream_if #(.item_t(out_item_t)) chars_if ();

    utf8_stream_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_if),
        .chars (chars_if)
    );

    always #5 clk = ~clk;

    // decoder model state
    logic [7:0] held_bytes [HOLD_DEPTH];
    int         held_count;

    out_item_t  pending_chars [$];
    int         fail_count;
    int         report_count;
    int         burst_left;
    int         hold_requests;
    int         holds_served;
    stim_row_t  dir_rows [24];

    function automatic logic [7:0] peek_held(int k);
        return (k < held_count) ? held_bytes[k] : 8'h00;
    endfunction

    function automatic bit byte_known(int k, bit fin);
        return (k < held_count) || fin;
    endfunction

    function automatic bit is_cont(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Judges the form at the head of the held bytes; returns bytes used, 0 if more are needed.
    function automatic int judge_head(input bit fin, output logic [15:0] cp, output logic rep);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int span;
        int k;
        b0 = peek_held(0);
        rep = 1'b1;
        cp = REPL_CHAR;
        if (b0 < 8'h80)
        begin
            rep = 1'b0;
            cp = {8'h00, b0};
            return 1;
        end
        if (b0 < 8'hC0 || b0 >= 8'hFE)
            return 1;
        if (b0 < 8'hE0)
        begin
            if (!byte_known(1, fin))
                return 0;
            b1 = peek_held(1);
            if (!is_cont(b1))
                return 1;
            if (b0[7:1] == 7'b1100000)
                return 2;
            rep = 1'b0;
            cp = {5'b0, b0[4:0], b1[5:0]};
            return 2;
        end
        if (b0 < 8'hF0)
        begin
            if (!byte_known(1, fin))
                return 0;
            b1 = peek_held(1);
            if (!is_cont(b1))
                return 1;
            if (!byte_known(2, fin))
                return 0;
            b2 = peek_held(2);
            if (!is_cont(b2))
                return 2;
            if (b0 == 8'hED && b1[5])
                return 3;   // surrogate
            if (b0 == 8'hE0 && b1[7:5] == 3'b100)
                return 3;   // overlong
            rep = 1'b0;
            cp = {b0[3:0], b1[5:0], b2[5:0]};
            return 3;
        end
        span = (b0 < 8'hF8) ? 4 : (b0 < 8'hFC) ? 5 : 6;
        for (k = 1; k < span; k++)
        begin
            if (!byte_known(k, fin))
                return 0;
            b1 = peek_held(k);
            if (!b1[7])
                break;
        end
        return k;
    endfunction

    function automatic int decode_byte(input logic [7:0] b, input bit fin,
                                       output out_item_t res [HOLD_DEPTH]);
        int n;
        int used;
        logic [15:0] cp;
        logic rep;
        n = 0;
        for (int i = 0; i < HOLD_DEPTH; i++)
            res[i] = NO_WANT;
        if (held_count < HOLD_DEPTH)
        begin
            held_bytes[held_count] = b;
            held_count++;
        end
        while (held_count > 0 && n < HOLD_DEPTH)
        begin
            used = judge_head(fin, cp, rep);
            if (used == 0)
                break;
            if (used > held_count)
                used = held_count;
            res[n] = '{cp, rep, 1'b0, 1'b0};
            n++;
            for (int i = 0; i < HOLD_DEPTH; i++)
                held_bytes[i] = (i + used < HOLD_DEPTH) ? held_bytes[i + used] : 8'h00;
            held_count -= used;
        end
        if (n > 0)
        begin
            res[n-1].last_of_run = 1'b1;
            res[n-1].text_done = fin;
        end
        if (fin)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
                held_bytes[i] = 8'h00;
            held_count = 0;
        end
        return n;
    endfunction

    // Offers one byte; the sender runs in bursts with idle gaps between them.
    task automatic send_byte(input logic [7:0] b, input logic eot,
                             input logic pinned, input out_item_t want);
        out_item_t res [HOLD_DEPTH];
        int n;
        if (burst_left == 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.payload <= '{b, eot};
        do
            @(posedge clk);
        while (!bytes_if.ready);
        burst_left--;
        n = decode_byte(b, eot, res);
        if (pinned)
            pending_chars = {pending_chars, want};
        else
            for (int i = 0; i < n; i++)
                pending_chars = {pending_chars, res[i]};
    endtask

    task automatic wait_chars_drained();
        bytes_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_chars.size() > 0)
            @(posedge clk);
    endtask

    // Appends one random form, mostly well formed, to the text being built.
    task automatic add_random_form(ref logic [7:0] text_q [$]);
        int pick;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            text_q = {text_q, 8'($urandom_range(8'h00, 8'h7F))};
        else if (pick < 48)
        begin
            text_q = {text_q, 8'($urandom_range(8'hC2, 8'hDF))};
            text_q = {text_q, 8'h80 | 8'($urandom_range(0, 63))};
        end
        else if (pick < 64)
        begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            text_q = {text_q, lead};
            if (lead == 8'hE0)
                text_q = {text_q, 8'($urandom_range(8'hA0, 8'hBF))};
            else if (lead == 8'hED)
                text_q = {text_q, 8'($urandom_range(8'h80, 8'h9F))};
            else
                text_q = {text_q, 8'($urandom_range(8'h80, 8'hBF))};
            text_q = {text_q, 8'h80 | 8'($urandom_range(0, 63))};
        end
        else if (pick < 71)
        begin
            text_q = {text_q, 8'($urandom_range(8'hF0, 8'hFD))};
            repeat ($urandom_range(0, 5))
                text_q = {text_q, 8'h80 | 8'($urandom_range(0, 63))};
        end
        else if (pick < 77)
        begin
            // overlong two-byte, overlong three-byte, surrogate
            case ($urandom_range(0, 2))
                0: text_q = {text_q, 8'($urandom_range(8'hC0, 8'hC1))};
                1:
                begin
                    text_q = {text_q, 8'hE0};
                    text_q = {text_q, 8'($urandom_range(8'h80, 8'h9F))};
                end
                default:
                begin
                    text_q = {text_q, 8'hED};
                    text_q = {text_q, 8'($urandom_range(8'hA0, 8'hBF))};
                end
            endcase
            text_q = {text_q, 8'h80 | 8'($urandom_range(0, 63))};
        end
        else if (pick < 85)
        begin
            // truncated multi-byte form
            if ($urandom_range(0, 1) == 0)
                text_q = {text_q, 8'($urandom_range(8'hC2, 8'hDF))};
            else
            begin
                text_q = {text_q, 8'($urandom_range(8'hE1, 8'hEC))};
                if ($urandom_range(0, 1) == 0)
                    text_q = {text_q, 8'h80 | 8'($urandom_range(0, 63))};
            end
        end
        else
            text_q = {text_q, 8'($urandom_range(0, 255))};
    endtask

    // receiver: changing stall patterns, plus long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        int hold_left;
        mode = 0;
        mode_left = 0;
        phase = 0;
        hold_left = 0;
        holds_served = 0;
        chars_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chars_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                phase = (phase + 1) % 20;
                case (mode)
                    0: chars_if.ready <= 1'b1;
                    1: chars_if.ready <= 1'($urandom_range(0, 1));
                    2: chars_if.ready <= (phase % 4 == 0);
                    default: chars_if.ready <= (phase % 5 != 0);
                endcase
            end
        end
    end

    // char checker
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            got = chars_if.payload;
            if (pending_chars.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected char: cp=%h rep=%b last=%b done=%b",
                             got.code_point, got.was_replaced, got.last_of_run,
                             got.text_done);
                report_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (got.code_point !== want.code_point
                    || got.was_replaced !== want.was_replaced
                    || got.last_of_run !== want.last_of_run
                    || got.text_done !== want.text_done)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display("char mismatch: want cp=%h rep=%b last=%b done=%b,",
                                 want.code_point, want.was_replaced, want.last_of_run,
                                 want.text_done,
                                 " got cp=%h rep=%b last=%b done=%b",
                                 got.code_point, got.was_replaced,
                                 got.last_of_run, got.text_done);
                    report_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("utf8_stream_decoder regression: fail");
        $finish;
    end

    initial
    begin
        logic [7:0] text_q [$];
        int random_sent;
        int texts_sent;
        fail_count = 0;
        report_count = 0;
        burst_left = 0;
        hold_requests = 0;
        held_count = 0;
        for (int i = 0; i < HOLD_DEPTH; i++)
            held_bytes[i] = 8'h00;
        bytes_if.valid <= 1'b0;
        bytes_if.payload <= '0;

        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0}},
            '{8'h7F, 1'b1, 1'b1, '{16'h007F, 1'b0, 1'b1, 1'b1}},
            '{8'h80, 1'b0, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b0}},
            '{8'hFE, 1'b0, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b0}},
            '{8'hFF, 1'b0, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b0}},
            '{8'hC1, 1'b0, 1'b0, NO_WANT},
            '{8'hAF, 1'b0, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b0}},
            '{8'hE0, 1'b0, 1'b0, NO_WANT},
            '{8'h9F, 1'b0, 1'b0, NO_WANT},
            '{8'hBF, 1'b0, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b0}},
            '{8'hED, 1'b0, 1'b0, NO_WANT},
            '{8'hA0, 1'b0, 1'b0, NO_WANT},
            '{8'h80, 1'b0, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b0}},
            '{8'hEF, 1'b0, 1'b0, NO_WANT},
            '{8'hBF, 1'b0, 1'b0, NO_WANT},
            '{8'hBF, 1'b0, 1'b1, '{16'hFFFF, 1'b0, 1'b1, 1'b0}},
            '{8'hE2, 1'b0, 1'b0, NO_WANT},
            '{8'h28, 1'b0, 1'b0, NO_WANT},
            '{8'hE2, 1'b0, 1'b0, NO_WANT},
            '{8'h82, 1'b1, 1'b0, NO_WANT},
            '{8'hF8, 1'b0, 1'b0, NO_WANT},
            '{8'h80, 1'b0, 1'b0, NO_WANT},
            '{8'h41, 1'b0, 1'b0, NO_WANT},
            '{8'hF4, 1'b1, 1'b1, '{REPL_CHAR, 1'b1, 1'b1, 1'b1}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data_byte, dir_rows[i].end_of_text,
                      dir_rows[i].pinned, dir_rows[i].want);
        wait_chars_drained();

        random_sent = 0;
        texts_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 6))
                add_random_form(text_q);
            foreach (text_q[i])
            begin
                // stall the output for a long stretch while bytes keep coming
                if (random_sent == 60 || random_sent == 170)
                    hold_requests++;
                send_byte(text_q[i], i == text_q.size() - 1, 1'b0, NO_WANT);
                random_sent++;
            end
            texts_sent++;
            if (texts_sent == 12)
                wait_chars_drained();
        end

        wait_chars_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_chars.size() == 0)
            $display("utf8_stream_decoder regression: pass");
        else
            $display("utf8_stream_decoder regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/utf8d_pkg.sv
rtl/utf8d_stream_if.sv
rtl/utf8d_ctrl.sv
rtl/utf8d_datapath.sv
rtl/utf8_stream_decoder.sv
verif/testbench.sv
